// File: hdl/afl_pkg.sv
// afl_pkg: widths, aspect mode codes, ratio table and pipeline stage types
// for the aspect fit letterbox block. No dependencies.
`default_nettype none

package afl_pkg;

    localparam int DIM_W          = 15;
    localparam int OFF_W          = 14;
    localparam int MODE_W         = 3;
    localparam int ALIGN_BITS_DEF = 3;

    localparam int Q_W    = 5;
    localparam int PLOG_W = 3;
    localparam int WQ_W   = DIM_W + Q_W;
    localparam int HP_W   = DIM_W + 6;
    localparam int NUM_W  = HP_W + 1;

    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 26;
    localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [RECIP_W-1:0] RECIP_18 = RECIP_W'((RECIP_ONE + 18 - 1) / 18);
    localparam logic [RECIP_W-1:0] RECIP_6  = RECIP_W'((RECIP_ONE + 6 - 1) / 6);
    localparam logic [RECIP_W-1:0] RECIP_20 = RECIP_W'((RECIP_ONE + 20 - 1) / 20);
    localparam logic [RECIP_W-1:0] RECIP_54 = RECIP_W'((RECIP_ONE + 54 - 1) / 54);

    localparam logic [MODE_W-1:0] MODE_16_9  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_4_3   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_16_10 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_64_27 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_32_9  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NOFIT = 3'd5;

    // ratio p:q with p = 2^plog; recip = ceil(2^RECIP_SHIFT / (2q))
    typedef struct packed {
        logic [Q_W-1:0]     q;
        logic [PLOG_W-1:0]  plog;
        logic [RECIP_W-1:0] recip;
        logic               fit;
    } ratio_t;

    typedef struct packed {
        logic [DIM_W-1:0]   sw;
        logic [DIM_W-1:0]   sh;
        ratio_t             ratio;
        logic               fit_en;
        logic [WQ_W-1:0]    prod_wq;
        logic [HP_W-1:0]    prod_hp;
    } stage1_t;

    typedef struct packed {
        logic [DIM_W-1:0]   sw;
        logic [DIM_W-1:0]   sh;
        logic [RECIP_W-1:0] recip;
        logic               fit_en;
        logic               pillar;
        logic [NUM_W-1:0]   num_p;
        logic [DIM_W-1:0]   h_lb;
    } stage2_t;

    typedef struct packed {
        logic [DIM_W-1:0]   sw;
        logic [DIM_W-1:0]   sh;
        logic               fit_en;
        logic               pillar;
        logic [PROD_W-1:0]  prod;
        logic [DIM_W-1:0]   h_lb;
    } stage3_t;

    typedef struct packed {
        logic [DIM_W-1:0] fit_width;
        logic [DIM_W-1:0] fit_height;
        logic [OFF_W-1:0] offset_x;
        logic [OFF_W-1:0] offset_y;
        logic             fit_nonzero;
    } fit_t;

    function automatic ratio_t afl_ratio(input logic [MODE_W-1:0] mode);
        ratio_t r;
        r.q     = 5'd9;
        r.plog  = 3'd4;
        r.recip = RECIP_18;
        r.fit   = 1'b1;
        unique case (mode)
            MODE_4_3:
            begin
                r.q     = 5'd3;
                r.plog  = 3'd2;
                r.recip = RECIP_6;
            end
            MODE_16_10:
            begin
                r.q     = 5'd10;
                r.plog  = 3'd4;
                r.recip = RECIP_20;
            end
            MODE_64_27:
            begin
                r.q     = 5'd27;
                r.plog  = 3'd6;
                r.recip = RECIP_54;
            end
            MODE_32_9:
            begin
                r.q     = 5'd9;
                r.plog  = 3'd5;
                r.recip = RECIP_18;
            end
            MODE_NOFIT:
            begin
                r.fit = 1'b0;
            end
            default:
            begin
                r.q     = 5'd9;
                r.plog  = 3'd4;
                r.recip = RECIP_18;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/afl_size_if.sv
// afl_size_if: valid/ready channel carrying a surface size transaction.
// Depends on afl_pkg.
`default_nettype none

interface afl_size_if
    import afl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DIM_W-1:0] surface_width;
    logic [DIM_W-1:0] surface_height;

    modport source (output valid, output surface_width, output surface_height, input ready);
    modport sink   (input valid, input surface_width, input surface_height, output ready);
endinterface

`default_nettype wire

// File: hdl/afl_fit_if.sv
// afl_fit_if: valid/ready channel carrying a fitted rectangle transaction.
// Depends on afl_pkg.
`default_nettype none

interface afl_fit_if
    import afl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DIM_W-1:0] fit_width;
    logic [DIM_W-1:0] fit_height;
    logic [OFF_W-1:0] offset_x;
    logic [OFF_W-1:0] offset_y;
    logic             fit_nonzero;

    modport source (output valid, output fit_width, output fit_height, output offset_x,
                    output offset_y, output fit_nonzero, input ready);
    modport sink   (input valid, input fit_width, input fit_height, input offset_x,
                    input offset_y, input fit_nonzero, output ready);
endinterface

`default_nettype wire

// File: hdl/afl_out_calc.sv
// afl_out_calc: final stage logic; quotient select, alignment, clamp, offsets.
// Depends on afl_pkg.
`default_nettype none

module afl_out_calc
    import afl_pkg::*;
#(
    parameter int ALIGN_BITS = ALIGN_BITS_DEF
)(
    input  wire stage3_t s3,
    output fit_t        res
);

    localparam logic [QUOT_W-1:0] MASK_Q = ~(QUOT_W'((1 << ALIGN_BITS) - 1));
    localparam logic [DIM_W-1:0]  MASK_D = ~(DIM_W'((1 << ALIGN_BITS) - 1));

    logic [QUOT_W-1:0] quot;
    logic [QUOT_W-1:0] w_raw;
    logic [QUOT_W-1:0] w_al;
    logic [DIM_W-1:0]  h_raw;
    logic [DIM_W-1:0]  h_al;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  dx;
    logic [DIM_W-1:0]  dy;

    always_comb
    begin
        quot  = s3.prod[RECIP_SHIFT +: QUOT_W];
        w_raw = (s3.fit_en && s3.pillar) ? quot : QUOT_W'(s3.sw);
        h_raw = (s3.fit_en && !s3.pillar) ? s3.h_lb : s3.sh;
        w_al  = w_raw & MASK_Q;
        h_al  = h_raw & MASK_D;
        if (w_al > QUOT_W'(s3.sw))
        begin
            w = s3.sw & MASK_D;
        end
        else
        begin
            w = DIM_W'(w_al);
        end
        if (h_al > s3.sh)
        begin
            h = s3.sh & MASK_D;
        end
        else
        begin
            h = h_al;
        end
        dx = s3.sw - w;
        dy = s3.sh - h;
        res.fit_width   = w;
        res.fit_height  = h;
        res.offset_x    = dx[DIM_W-1:1];
        res.offset_y    = dy[DIM_W-1:1];
        res.fit_nonzero = (w != '0) && (h != '0);
    end

endmodule

`default_nettype wire

// File: hdl/aspect_fit_letterbox.sv
// aspect_fit_letterbox: top level; mode register and four-stage fit pipeline.
// Depends on afl_pkg, afl_size_if, afl_fit_if and afl_out_calc.
//
//  channel   dir  handshake    payload
//  size_in   in   valid/ready  surface_width, surface_height
//  fit_out   out  valid/ready  fit_width, fit_height, offset_x, offset_y, fit_nonzero
//  cfg       in   cfg_wr_en    cfg_wr_data (aspect mode)
//
// One transaction per cycle while fit_out does not stall; an accepted one passes s1, s2, s3 and out regs to fit_out.
// Stages: products, compare and numerators, reciprocal multiply, align and output.
// The 22x26 reciprocal multiply sets the critical stage.
// Each stage advances when empty or when the next one advances, so bubbles collapse.
// Reset clears the mode to 16:9 and empties the pipeline.
`default_nettype none

module aspect_fit_letterbox
    import afl_pkg::*;
#(
    parameter int ALIGN_BITS = ALIGN_BITS_DEF
)(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_wr_en,
    input  wire [MODE_W-1:0]   cfg_wr_data,
    afl_size_if.sink           size_in,
    afl_fit_if.source          fit_out
);

    logic [MODE_W-1:0] aspect_mode_reg;

    logic    s1_valid_reg;
    logic    s2_valid_reg;
    logic    s3_valid_reg;
    logic    out_valid_reg;
    stage1_t s1_reg;
    stage1_t s1_next;
    stage2_t s2_reg;
    stage2_t s2_next;
    stage3_t s3_reg;
    stage3_t s3_next;
    fit_t    out_reg;
    fit_t    out_next;

    logic adv1;
    logic adv2;
    logic adv3;
    logic adv4;

    ratio_t             ratio_in;
    logic [WQ_W:0]      lb_num;
    logic [WQ_W:0]      lb_quot;

    always_comb
    begin
        adv4 = !out_valid_reg || fit_out.ready;
        adv3 = !s3_valid_reg || adv4;
        adv2 = !s2_valid_reg || adv3;
        adv1 = !s1_valid_reg || adv2;
    end

    assign size_in.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aspect_mode_reg <= MODE_16_9;
        end
        else if (cfg_wr_en)
        begin
            aspect_mode_reg <= cfg_wr_data;
        end
    end

    // stage 1: decode ratio, form cross products
    always_comb
    begin
        ratio_in        = afl_ratio(aspect_mode_reg);
        s1_next.sw      = size_in.surface_width;
        s1_next.sh      = size_in.surface_height;
        s1_next.ratio   = ratio_in;
        s1_next.fit_en  = ratio_in.fit && (size_in.surface_width != '0)
                          && (size_in.surface_height != '0);
        s1_next.prod_wq = WQ_W'(size_in.surface_width) * WQ_W'(ratio_in.q);
        s1_next.prod_hp = HP_W'(size_in.surface_height) << ratio_in.plog;
    end

    // stage 2: pick pillarbox or letterbox, build numerators
    always_comb
    begin
        lb_num          = {s1_reg.prod_wq, 1'b0} + ((WQ_W + 1)'(1) << s1_reg.ratio.plog);
        lb_quot         = lb_num >> (s1_reg.ratio.plog + PLOG_W'(1));
        s2_next.sw      = s1_reg.sw;
        s2_next.sh      = s1_reg.sh;
        s2_next.recip   = s1_reg.ratio.recip;
        s2_next.fit_en  = s1_reg.fit_en;
        s2_next.pillar  = HP_W'(s1_reg.prod_wq) >= s1_reg.prod_hp;
        s2_next.num_p   = {s1_reg.prod_hp, 1'b0} + NUM_W'(s1_reg.ratio.q);
        s2_next.h_lb    = DIM_W'(lb_quot);
    end

    // stage 3: divide by 2q through reciprocal multiply
    always_comb
    begin
        s3_next.sw     = s2_reg.sw;
        s3_next.sh     = s2_reg.sh;
        s3_next.fit_en = s2_reg.fit_en;
        s3_next.pillar = s2_reg.pillar;
        s3_next.prod   = PROD_W'(s2_reg.num_p) * PROD_W'(s2_reg.recip);
        s3_next.h_lb   = s2_reg.h_lb;
    end

    afl_out_calc #(
        .ALIGN_BITS (ALIGN_BITS)
    ) u_out_calc (
        .s3  (s3_reg),
        .res (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= size_in.valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && size_in.valid)
        begin
            s1_reg <= s1_next;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (adv3 && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
        if (adv4 && s3_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign fit_out.valid       = out_valid_reg;
    assign fit_out.fit_width   = out_reg.fit_width;
    assign fit_out.fit_height  = out_reg.fit_height;
    assign fit_out.offset_x    = out_reg.offset_x;
    assign fit_out.offset_y    = out_reg.offset_y;
    assign fit_out.fit_nonzero = out_reg.fit_nonzero;

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (size_in.valid && size_in.ready) |=> s1_valid_reg)
        else $error("accepted transaction did not reach stage 1");

    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !adv4) |=> (s3_valid_reg && $stable(s3_reg)))
        else $error("stage 3 changed while stalled");

    a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((out_reg.fit_width | out_reg.fit_height)
                            & DIM_W'((1 << ALIGN_BITS) - 1)) == '0))
        else $error("fitted size not aligned");

    a_nonzero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.fit_nonzero
                           == ((out_reg.fit_width != '0) && (out_reg.fit_height != '0))))
        else $error("nonzero flag disagrees with fitted size");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// tb_top: self-checking bench for aspect_fit_letterbox. Drives surface sizes
// under every aspect mode with random handshake gaps and checks each fitted rectangle.
// Depends on afl_pkg, afl_size_if, afl_fit_if and the aspect_fit_letterbox RTL.

module tb_top;
    import afl_pkg::*;

    localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int DRAIN_LIMIT      = 5000;

    class fit_checker;
        logic [MODE_W-1:0] mode;
        fit_t              expected_fits[$];
        int                mismatches;

        function new();
            mode        = MODE_16_9;
            mismatches  = 0;
        endfunction

        function bit ratio_terms(input logic [MODE_W-1:0] m,
                                 output longint unsigned p, output longint unsigned q);
            p = 16;
            q = 9;
            ratio_terms = 1'b1;
            case (m)
                MODE_4_3:
                begin
                    p = 4;
                    q = 3;
                end
                MODE_16_10:
                begin
                    p = 16;
                    q = 10;
                end
                MODE_64_27:
                begin
                    p = 64;
                    q = 27;
                end
                MODE_32_9:
                begin
                    p = 32;
                    q = 9;
                end
                MODE_NOFIT:
                begin
                    ratio_terms = 1'b0;
                end
                default:
                begin
                    p = 16;
                    q = 9;
                end
            endcase
        endfunction

        function fit_t fit_rect(input logic [DIM_W-1:0] sw_in, input logic [DIM_W-1:0] sh_in);
            longint unsigned sw, sh, w, h, p, q, mask, ox, oy;
            bit              do_fit;
            fit_t            r;
            sw     = sw_in;
            sh     = sh_in;
            mask   = ~((64'd1 << ALIGN_BITS_DEF) - 64'd1);
            do_fit = ratio_terms(mode, p, q);
            w      = sw;
            h      = sh;
            if (do_fit && sw != 0 && sh != 0)
            begin
                if (sw * q >= sh * p)
                    w = (2 * sh * p + q) / (2 * q);
                else
                    h = (2 * sw * q + p) / (2 * p);
            end
            w = w & mask;
            h = h & mask;
            if (w > sw)
                w = sw & mask;
            if (h > sh)
                h = sh & mask;
            ox = (sw - w) >> 1;
            oy = (sh - h) >> 1;
            r.fit_width   = w[DIM_W-1:0];
            r.fit_height  = h[DIM_W-1:0];
            r.offset_x    = ox[OFF_W-1:0];
            r.offset_y    = oy[OFF_W-1:0];
            r.fit_nonzero = (w != 0 && h != 0);
            return r;
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void note_size(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh);
            expected_fits.push_back(fit_rect(sw, sh));
        endfunction

        task check_fit(input logic [DIM_W-1:0] fw, input logic [DIM_W-1:0] fh,
                       input logic [OFF_W-1:0] ox, input logic [OFF_W-1:0] oy,
                       input logic nz);
            fit_t exp_fit;
            if (expected_fits.size() == 0)
            begin
                report("fit transaction with none expected");
            end
            else
            begin
                exp_fit = expected_fits.pop_front();
                if (fw !== exp_fit.fit_width)
                    report($sformatf("fit_width %0d, expected %0d", fw, exp_fit.fit_width));
                if (fh !== exp_fit.fit_height)
                    report($sformatf("fit_height %0d, expected %0d", fh, exp_fit.fit_height));
                if (ox !== exp_fit.offset_x)
                    report($sformatf("offset_x %0d, expected %0d", ox, exp_fit.offset_x));
                if (oy !== exp_fit.offset_y)
                    report($sformatf("offset_y %0d, expected %0d", oy, exp_fit.offset_y));
                if (nz !== exp_fit.fit_nonzero)
                    report($sformatf("fit_nonzero %0b, expected %0b", nz, exp_fit.fit_nonzero));
            end
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [MODE_W-1:0] cfg_wr_data;
    bit                tx_steady;
    fit_checker        sb;

    afl_size_if size_if();
    afl_fit_if  fit_if();

    aspect_fit_letterbox #(
        .ALIGN_BITS (ALIGN_BITS_DEF)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .size_in     (size_if),
        .fit_out     (fit_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAIL aspect_fit_letterbox");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (size_if.valid && size_if.ready)
                sb.note_size(size_if.surface_width, size_if.surface_height);
            if (fit_if.valid && fit_if.ready)
                sb.check_fit(fit_if.fit_width, fit_if.fit_height, fit_if.offset_x,
                             fit_if.offset_y, fit_if.fit_nonzero);
        end
    end

    // fit_out side: random hold per transaction, bursts with none, one long hold
    initial
    begin
        int hold;
        int taken;
        taken = 0;
        fit_if.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (taken == LONG_HOLD_AT)
                hold = LONG_HOLD_CYCLES;
            else if ((taken / 100) % 4 == 1)
                hold = 0;
            else
                hold = $urandom_range(0, 5);
            if (hold != 0)
            begin
                fit_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            fit_if.ready <= 1'b1;
            @(posedge clk);
            while (!fit_if.valid)
                @(posedge clk);
            taken++;
        end
    end

    task automatic send_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            size_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        size_if.valid          <= 1'b1;
        size_if.surface_width  <= w;
        size_if.surface_height <= h;
        @(posedge clk);
        while (!size_if.ready)
            @(posedge clk);
    endtask

    task automatic settle();
        size_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_fits.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.mode = m;
    endtask

    // bias toward sizes near the target ratio, where the rounding and the compare matter
    task automatic pick_size(input logic [MODE_W-1:0] m,
                             output logic [DIM_W-1:0] w, output logic [DIM_W-1:0] h);
        longint unsigned p, q;
        longint          other;
        int              base;
        int              kind;
        bit              unused_fit;
        unused_fit = sb.ratio_terms(m, p, q);
        kind       = $urandom_range(0, 9);
        case (kind)
            0:
            begin
                if ($urandom_range(0, 1))
                begin
                    w = '0;
                    h = DIM_W'($urandom);
                end
                else
                begin
                    w = DIM_W'($urandom);
                    h = '0;
                end
            end
            1:
            begin
                w = DIM_W'($urandom_range(0, 40));
                h = DIM_W'($urandom_range(0, 40));
            end
            2, 3:
            begin
                w = DIM_W'($urandom);
                h = DIM_W'($urandom);
            end
            default:
            begin
                base = $urandom_range(0, 1) ? $urandom_range(1, 2048) : $urandom_range(1, 32767);
                if ($urandom_range(0, 1))
                    other = (longint'(base) * p + q / 2) / q;
                else
                    other = (longint'(base) * q + p / 2) / p;
                other = other + $urandom_range(0, 6) - 3;
                if (other < 0)
                    other = 0;
                if (other > 32767)
                    other = 32767;
                if ($urandom_range(0, 1))
                begin
                    h = DIM_W'(base);
                    w = DIM_W'(other);
                end
                else
                begin
                    w = DIM_W'(base);
                    h = DIM_W'(other);
                end
                if (kind >= 7)
                begin
                    w = DIM_W'(base);
                    h = DIM_W'(other);
                end
            end
        endcase
    endtask

    initial
    begin
        int unsigned       dir_w[17];
        int unsigned       dir_h[17];
        logic [MODE_W-1:0] plan[10];
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        int                waited;
        dir_w = '{0, 0, 1920, 32767, 16384, 1920, 1, 7, 8, 32767, 1, 16, 1440, 1080,
                  16384, 17, 15};
        dir_h = '{0, 1080, 0, 32767, 16384, 1080, 1, 7, 8, 1, 32767, 9, 1080, 1920,
                  9216, 9, 9};
        plan  = '{MODE_4_3, MODE_16_10, MODE_64_27, MODE_32_9, MODE_NOFIT, MODE_RSVD_6,
                  MODE_16_9, MODE_RSVD_7, MODE_W'($urandom_range(0, 7)),
                  MODE_W'($urandom_range(0, 7))};
        sb = new();
        tx_steady = 1'b0;
        rst_n                  <= 1'b0;
        cfg_wr_en              <= 1'b0;
        cfg_wr_data            <= MODE_16_9;
        size_if.valid          <= 1'b0;
        size_if.surface_width  <= '0;
        size_if.surface_height <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 17; i++)
            send_size(DIM_W'(dir_w[i]), DIM_W'(dir_h[i]));
        settle();
        write_mode(MODE_NOFIT);
        send_size(15'd1921, 15'd1083);
        send_size(15'd32767, 15'd32767);
        settle();
        write_mode(MODE_RSVD_7);
        send_size(15'd1920, 15'd1080);
        send_size(15'd1000, 15'd1000);
        send_size(15'd0, 15'd5);
        settle();

        for (int ph = 0; ph < 10; ph++)
        begin
            write_mode(plan[ph]);
            tx_steady = (ph % 3 == 2);
            for (int n = 0; n < 120; n++)
            begin
                pick_size(plan[ph], w, h);
                send_size(w, h);
            end
            settle();
        end

        waited = 0;
        while (sb.expected_fits.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (sb.expected_fits.size() != 0)
            sb.report($sformatf("%0d fit transactions never arrived", sb.expected_fits.size()));

        if (sb.mismatches == 0)
            $display("PASS aspect_fit_letterbox");
        else
            $display("FAIL aspect_fit_letterbox");
        $finish;
    end

endmodule

// File: files.f
hdl/afl_pkg.sv
hdl/afl_size_if.sv
hdl/afl_fit_if.sv
hdl/afl_out_calc.sv
hdl/aspect_fit_letterbox.sv
sim/tb_top.sv
